>>> sv/adsr_envelope_generator_top_defines.svh
// ---------------------------------------------------------------------------
// ADSR envelope generator assertion macros
// Shared property forms for the concurrent checks of the envelope block.
// ---------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("adsr check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("adsr check failed: next-cycle implication");

`endif

>>> sv/adsr_pkg.sv
// ---------------------------------------------------------------------------
// ADSR package
// Default sizes, register indexes, stage codes and shared types.
// ---------------------------------------------------------------------------
package adsr_pkg;

  localparam int COUNT_BITS_DEF      = 20;
  localparam int LEVEL_FRAC_BITS_DEF = 15;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int STAGE_BITS          = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SUSTAIN = 2'd3;

  typedef enum logic [STAGE_BITS-1:0] {
    STAGE_ATTACK  = 3'd0,
    STAGE_DECAY   = 3'd1,
    STAGE_SUSTAIN = 3'd2,
    STAGE_RELEASE = 3'd3,
    STAGE_DONE    = 3'd4
  } adsr_stage_t;

  // Status of a finished sample handed from the controller to the output stage.
  typedef struct packed {
    logic        valid;
    logic        sounding;
    adsr_stage_t stage;
  } adsr_res_t;

endpackage

>>> sv/adsr_muldiv.sv
// ---------------------------------------------------------------------------
// ADSR serial multiply-divide unit
// Computes op_a * op_b / divisor, one product bit and then one quotient bit
// per cycle. The caller guarantees op_b <= divisor and op_a <= full scale.
// ---------------------------------------------------------------------------
module adsr_muldiv import adsr_pkg::*; #(
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [LEVEL_FRAC_BITS:0] op_a,
  input  logic [COUNT_BITS-1:0]    op_b,
  input  logic [COUNT_BITS-1:0]    divisor,
  output logic                     done,
  output logic [LEVEL_FRAC_BITS:0] quot
);

  localparam int LW    = LEVEL_FRAC_BITS + 1;
  localparam int PW    = LW + COUNT_BITS;
  localparam int CNT_W = $clog2(LW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(LW - 1);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic [PW-1:0]         acc;
  logic [LW-1:0]         a_sh;
  logic [COUNT_BITS-1:0] b_reg;
  logic [COUNT_BITS-1:0] d_reg;
  logic [COUNT_BITS-1:0] rem;

  logic [PW-1:0]         acc_next;
  logic [COUNT_BITS:0]   rem_try;
  logic [COUNT_BITS:0]   rem_next;
  logic                  q_bit;

  always_comb begin
    acc_next = {acc[PW-2:0], 1'b0} + (a_sh[LW-1] ? PW'(b_reg) : '0);
    rem_try  = {rem, a_sh[LW-1]};
    q_bit    = (rem_try >= {1'b0, d_reg});
    rem_next = q_bit ? (rem_try - {1'b0, d_reg}) : rem_try;
  end

  // The multiplier bits leave a_sh at the top; during division the low
  // product bits leave at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          done <= 1'b0;
          if (start) begin
            a_sh  <= op_a;
            b_reg <= op_b;
            d_reg <= divisor;
            acc   <= '0;
            cnt   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          done <= 1'b0;
          acc  <= acc_next;
          if (cnt == LAST) begin
            cnt   <= '0;
            rem   <= acc_next[PW-1:LW];
            a_sh  <= acc_next[LW-1:0];
            state <= M_DIV;
          end else begin
            cnt  <= cnt + 1'b1;
            a_sh <= {a_sh[LW-2:0], 1'b0};
          end
        end
        M_DIV: begin
          rem  <= rem_next[COUNT_BITS-1:0];
          a_sh <= {a_sh[LW-2:0], q_bit};
          if (cnt == LAST) begin
            cnt   <= '0;
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            cnt  <= cnt + 1'b1;
            done <= 1'b0;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= M_IDLE;
        end
      endcase
    end
  end

  assign quot = a_sh;

endmodule

>>> sv/adsr_ctrl.sv
// ---------------------------------------------------------------------------
// ADSR controller
// Holds the configuration and envelope state, applies note events and
// stage transitions, and drives the serial multiply-divide unit.
// ---------------------------------------------------------------------------
`include "adsr_envelope_generator_top_defines.svh"

module adsr_ctrl import adsr_pkg::*; #(
  parameter int COUNT_BITS      = COUNT_BITS_DEF,
  parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
  parameter int CFG_W           = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      note_on,
  input  logic                      note_off,
  output logic                      md_start,
  output logic [LEVEL_FRAC_BITS:0]  md_op_a,
  output logic [COUNT_BITS-1:0]     md_op_b,
  output logic [COUNT_BITS-1:0]     md_divisor,
  input  logic                      md_done,
  input  logic [LEVEL_FRAC_BITS:0]  md_quot,
  output adsr_res_t                 res,
  output logic [LEVEL_FRAC_BITS:0]  res_env,
  input  logic                      res_take
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam logic [LW-1:0]         FULL    = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] ONE_LEN = COUNT_BITS'(1);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_RESULT} state_t;

  state_t                state;
  adsr_stage_t           stage_reg;
  adsr_stage_t           work_stage;
  adsr_stage_t           res_stage;
  logic [COUNT_BITS-1:0] position;
  logic [LW-1:0]         held;
  logic                  pending;
  logic                  res_sounding;
  logic [COUNT_BITS-1:0] attack_len;
  logic [COUNT_BITS-1:0] decay_len;
  logic [COUNT_BITS-1:0] release_len;
  logic [LW-1:0]         sustain;

  logic                  accept;
  adsr_stage_t           st0;
  adsr_stage_t           st1;
  logic [COUNT_BITS-1:0] pos0;
  logic [COUNT_BITS-1:0] pos1;
  logic [LW-1:0]         held0;
  logic                  pend0;
  logic                  pend1;
  logic                  go_rel;
  logic [LW-1:0]         sus_c;
  logic [COUNT_BITS-1:0] len_sel;
  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] p;
  logic [COUNT_BITS:0]   pos_inc;
  logic                  stage_end;
  logic [LW-1:0]         env_calc;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // A note-on restarts first, then a note-off sets the pending flag, which
  // moves any active stage other than release into release.
  always_comb begin
    st0    = note_on ? STAGE_ATTACK : stage_reg;
    pos0   = note_on ? '0 : position;
    held0  = note_on ? '0 : held;
    pend0  = (note_on ? 1'b0 : pending) | note_off;
    go_rel = pend0 && (st0 != STAGE_RELEASE) && (st0 != STAGE_DONE);
    st1    = go_rel ? STAGE_RELEASE : st0;
    pos1   = go_rel ? '0 : pos0;
    pend1  = go_rel ? 1'b0 : pend0;
    sus_c  = (sustain > FULL) ? FULL : sustain;

    case (st1)
      STAGE_ATTACK: len_sel = attack_len;
      STAGE_DECAY:  len_sel = decay_len;
      default:      len_sel = release_len;
    endcase
    len       = (len_sel == '0) ? ONE_LEN : len_sel;
    p         = (pos1 > len) ? len : pos1;
    pos_inc   = {1'b0, pos1} + {{COUNT_BITS{1'b0}}, 1'b1};
    stage_end = (pos_inc >= {1'b0, len});

    case (st1)
      STAGE_ATTACK: md_op_a = FULL;
      STAGE_DECAY:  md_op_a = FULL - sus_c;
      default:      md_op_a = held0;
    endcase
    md_op_b    = (st1 == STAGE_RELEASE) ? (len - p) : p;
    md_divisor = len;
    md_start   = accept && ((st1 == STAGE_ATTACK) || (st1 == STAGE_DECAY) ||
                            ((st1 == STAGE_RELEASE) && !stage_end));

    env_calc = (work_stage == STAGE_DECAY) ? (FULL - md_quot) : md_quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stage_reg    <= STAGE_DONE;
      work_stage   <= STAGE_DONE;
      res_stage    <= STAGE_DONE;
      res_sounding <= 1'b0;
      res_env      <= '0;
      position     <= '0;
      held         <= '0;
      pending      <= 1'b0;
      attack_len   <= ONE_LEN;
      decay_len    <= ONE_LEN;
      release_len  <= ONE_LEN;
      sustain      <= FULL;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ATTACK:  attack_len  <= cfg_data[COUNT_BITS-1:0];
          CFG_DECAY:   decay_len   <= cfg_data[COUNT_BITS-1:0];
          CFG_RELEASE: release_len <= cfg_data[COUNT_BITS-1:0];
          CFG_SUSTAIN: sustain     <= cfg_data[LW-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            // The end of release also drops a note-off that arrived during it.
            pending    <= ((st1 == STAGE_RELEASE) && stage_end) ? 1'b0 : pend1;
            held       <= (st1 == STAGE_SUSTAIN) ? sus_c : held0;
            work_stage <= st1;
            case (st1)
              STAGE_ATTACK: begin
                position  <= stage_end ? '0 : pos_inc[COUNT_BITS-1:0];
                stage_reg <= stage_end ? STAGE_DECAY : STAGE_ATTACK;
                state     <= S_CALC;
              end
              STAGE_DECAY: begin
                position  <= stage_end ? '0 : pos_inc[COUNT_BITS-1:0];
                stage_reg <= stage_end ? STAGE_SUSTAIN : STAGE_DECAY;
                state     <= S_CALC;
              end
              STAGE_SUSTAIN: begin
                position     <= pos1;
                stage_reg    <= STAGE_SUSTAIN;
                res_env      <= sus_c;
                res_sounding <= 1'b1;
                res_stage    <= STAGE_SUSTAIN;
                state        <= S_RESULT;
              end
              STAGE_RELEASE: begin
                if (stage_end) begin
                  position     <= '0;
                  stage_reg    <= STAGE_DONE;
                  res_env      <= '0;
                  res_sounding <= 1'b0;
                  res_stage    <= STAGE_DONE;
                  state        <= S_RESULT;
                end else begin
                  position  <= pos_inc[COUNT_BITS-1:0];
                  stage_reg <= STAGE_RELEASE;
                  state     <= S_CALC;
                end
              end
              default: begin
                position     <= pos1;
                stage_reg    <= STAGE_DONE;
                res_env      <= '0;
                res_sounding <= 1'b0;
                res_stage    <= STAGE_DONE;
                state        <= S_RESULT;
              end
            endcase
          end
        end
        S_CALC: begin
          if (md_done) begin
            res_env      <= env_calc;
            res_sounding <= 1'b1;
            res_stage    <= stage_reg;
            // Release scales the level captured before it, so it keeps it.
            if (work_stage != STAGE_RELEASE) begin
              held <= env_calc;
            end
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.valid    = (state == S_RESULT);
    res.sounding = res_sounding;
    res.stage    = res_stage;
  end

  `ADSR_ASSERT_IMPL(a_done_while_calc, clk, rst, md_done, state == S_CALC)
  `ADSR_ASSERT_NEXT(a_start_enters_calc, clk, rst, md_start, state == S_CALC)
  `ADSR_ASSERT_IMPL(a_silent_is_zero, clk, rst, res.valid && !res.sounding, res_env == '0)
  `ADSR_ASSERT_IMPL(a_sounding_vs_stage, clk, rst, res.valid, res.sounding == (res.stage != STAGE_DONE))

endmodule

>>> sv/adsr_envelope_generator_top.sv
// ---------------------------------------------------------------------------
// Linear ADSR envelope generator
// Produces one Q1.15 envelope gain per request, one request per sample tick.
// ---------------------------------------------------------------------------
// Usage:
//   Each input request carries note_on and note_off for one sample tick and
//   yields exactly one output request with envelope, sounding and stage.
//   Both channels use valid/stall; a request moves when valid is high and
//   stall is low. Write registers via cfg_wr_en, cfg_index and cfg_data
//   only while no request is in flight; the block does not enforce it.
//   Attack, decay and release samples run a serial multiply then a serial
//   restoring divide in the shared unit, one bit per cycle; the result then
//   passes through the controller's result register to the output register,
//   and the next request is taken only after it has left the controller.
//   Sustain, done and the final release sample skip the unit and go
//   straight to the controller's result register.
//   Reset puts the envelope in done with its control state cleared and the
//   registers at 1, 1, 1 and full scale.
//   A stalled result waits in the output register; the block still accepts
//   one more request and finishes it, then keeps in_stall high until the
//   output register frees up.
// ---------------------------------------------------------------------------
module adsr_envelope_generator_top import adsr_pkg::*; #(
  parameter int  COUNT_BITS      = COUNT_BITS_DEF,
  parameter int  LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
  localparam int CFG_W = (COUNT_BITS > LEVEL_FRAC_BITS) ? COUNT_BITS : LEVEL_FRAC_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      note_on,
  input  logic                      note_off,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LEVEL_FRAC_BITS:0]  envelope,
  output logic                      sounding,
  output logic [STAGE_BITS-1:0]     stage
);

  logic                     md_start;
  logic [LEVEL_FRAC_BITS:0] md_op_a;
  logic [COUNT_BITS-1:0]    md_op_b;
  logic [COUNT_BITS-1:0]    md_divisor;
  logic                     md_done;
  logic [LEVEL_FRAC_BITS:0] md_quot;
  adsr_res_t                res;
  logic [LEVEL_FRAC_BITS:0] res_env;
  logic                     res_take;

  adsr_ctrl #(
    .COUNT_BITS      (COUNT_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS),
    .CFG_W           (CFG_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .note_on    (note_on),
    .note_off   (note_off),
    .md_start   (md_start),
    .md_op_a    (md_op_a),
    .md_op_b    (md_op_b),
    .md_divisor (md_divisor),
    .md_done    (md_done),
    .md_quot    (md_quot),
    .res        (res),
    .res_env    (res_env),
    .res_take   (res_take)
  );

  adsr_muldiv #(
    .COUNT_BITS      (COUNT_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_muldiv (
    .clk     (clk),
    .rst     (rst),
    .start   (md_start),
    .op_a    (md_op_a),
    .op_b    (md_op_b),
    .divisor (md_divisor),
    .done    (md_done),
    .quot    (md_quot)
  );

  // The output register loads a waiting result whenever it is empty or being drained.
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      envelope <= res_env;
      sounding <= res.sounding;
      stage    <= res.stage;
    end
  end

endmodule
